// ----- rtl/vaft_pkg.sv -----
// shared constants, types and the micro-rotation angle function of the vector angle block
package vaft_pkg;

  // default number of micro-rotations (legal range 16 to 40)
  localparam int unsigned ITERATIONS_DEF = 32;

  // fraction bits of the internal angle
  localparam int unsigned FRAC = 60;
  // coordinate and difference widths
  localparam int unsigned CW = 32;
  localparam int unsigned DW = CW + 1;
  // normalized operand width, top bit is the normalization target
  localparam int unsigned NW = 59;
  // rotation datapath widths (x, y and z all stay below 2^61 in magnitude)
  localparam int unsigned XW = 62;
  localparam int unsigned ZW = 62;
  // octant angle after unfolding (below pi/2) and full-turn angle (below 2*pi)
  localparam int unsigned OW = 61;
  localparam int unsigned FW = 63;
  // result angle width
  localparam int unsigned AW = 32;

  localparam logic [63:0] PI_F         = 64'h3243F6A8885A308D;
  localparam logic [63:0] HALF_PI_F    = 64'h1921FB54442D1846;
  localparam logic [63:0] QUARTER_PI_F = 64'h0C90FDAA22168C23;
  localparam logic [63:0] TWO_PI_F     = 64'h6487ED5110B4611A;
  localparam logic [AW-1:0] ANGLE_MAX  = 32'd3373259425;

  // which way the octant angle is unfolded into the full turn
  typedef enum logic [1:0] {
    QUAD_FIRST  = 2'd0,  // angle as is
    QUAD_SECOND = 2'd1,  // pi minus angle
    QUAD_THIRD  = 2'd2,  // pi plus angle
    QUAD_FOURTH = 2'd3   // 2*pi minus angle
  } quad_t;

  // item flags carried alongside the rotation datapath
  typedef struct packed {
    logic  eq;
    logic  swap;
    quad_t quad;
  } side_t;

  // atan(2^-idx) at FRAC fraction bits, alternating power series, each term truncated
  function automatic logic [FRAC-1:0] micro_angle(input int unsigned idx);
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] quo;
    logic [63:0] rem;
    logic [63:0] den;
    int unsigned k;
    int unsigned sh;
    sum = 64'd0;
    k = 0;
    if (idx == 0) begin
      return QUARTER_PI_F[FRAC-1:0];
    end
    for (sh = idx; sh < FRAC; sh += 2 * idx) begin
      term = (64'd1 << FRAC) >> sh;
      den = 64'(2 * k + 1);
      quo = 64'd0;
      rem = 64'd0;
      // shift-subtract quotient of term by the odd series index
      for (int b = 63; b >= 0; b--) begin
        rem = {rem[62:0], term[b]};
        if (rem >= den) begin
          rem = rem - den;
          quo[b] = 1'b1;
        end
      end
      if (k[0]) begin
        sum = sum - quo;
      end else begin
        sum = sum + quo;
      end
      k++;
    end
    return sum[FRAC-1:0];
  endfunction

endpackage

// ----- rtl/vaft_ifs.sv -----
// valid/ready channel interfaces for point pairs and angle results
interface vaft_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] p_x;
  logic signed [31:0] p_y;
  logic signed [31:0] q_x;
  logic signed [31:0] q_y;

  modport source (output valid, output p_x, output p_y, output q_x, output q_y,
                  input ready);
  modport sink   (input valid, input p_x, input p_y, input q_x, input q_y,
                  output ready);
endinterface

interface vaft_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] angle;
  logic        points_equal;

  modport source (output valid, output angle, output points_equal, input ready);
  modport sink   (input valid, input angle, input points_equal, output ready);
endinterface

// ----- rtl/vaft_rot.sv -----
// one registered cordic micro-rotation stage in vectoring mode
module vaft_rot import vaft_pkg::*; #(
  parameter int unsigned STAGE = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic signed [XW-1:0] x_in,
  input  logic signed [XW-1:0] y_in,
  input  logic signed [ZW-1:0] z_in,
  input  side_t                side_in,
  output logic                 out_valid,
  output logic signed [XW-1:0] x_out,
  output logic signed [XW-1:0] y_out,
  output logic signed [ZW-1:0] z_out,
  output side_t                side_out
);

  localparam logic signed [ZW-1:0] ANGLE = {{(ZW - FRAC){1'b0}}, micro_angle(STAGE)};

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [XW-1:0] x_next;
  logic signed [XW-1:0] y_next;
  logic signed [ZW-1:0] z_next;

  // floor shifts
  assign xs = x_in >>> STAGE;
  assign ys = y_in >>> STAGE;

  // rotate toward y = 0
  always_comb begin
    if (!y_in[XW-1]) begin
      x_next = x_in + ys;
      y_next = y_in - xs;
      z_next = z_in + ANGLE;
    end else begin
      x_next = x_in - ys;
      y_next = y_in + xs;
      z_next = z_in - ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_out    <= x_next;
      y_out    <= y_next;
      z_out    <= z_next;
      side_out <= side_in;
    end
  end

endmodule

// ----- rtl/vaft_obuf.sv -----
// output register with skid stage for the angle result channel
module vaft_obuf import vaft_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [AW-1:0] angle_in,
  input  logic          eq_in,
  output logic          in_ready,
  vaft_out_if.source    res
);

  logic          out_valid;
  logic [AW-1:0] out_angle;
  logic          out_eq;
  logic          skid_valid;
  logic [AW-1:0] skid_angle;
  logic          skid_eq;
  logic          pop;
  logic          push;

  assign in_ready = !skid_valid;
  assign pop      = out_valid && res.ready;
  assign push     = in_valid && !skid_valid;

  assign res.valid        = out_valid;
  assign res.angle        = out_angle;
  assign res.points_equal = out_eq;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_angle <= skid_angle;
        out_eq    <= skid_eq;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_angle <= angle_in;
        out_eq    <= eq_in;
      end else begin
        skid_angle <= angle_in;
        skid_eq    <= eq_in;
      end
    end
  end

endmodule

// ----- rtl/vector_angle_full_turn_top.sv -----
// top level of the full-turn vector angle pipeline (cordic vectoring)
// Takes point pairs p, q on the pts channel and returns on the res channel the direction
// of q - p, counter-clockwise from the +x axis, as an unsigned angle in [0, 2*pi) with 29
// fraction bits (within 4 lsb of exact); equal points give points_equal = 1 and angle 0.
// The block is a fully unrolled pipeline with one cordic micro-rotation per stage, so a
// new item is taken every clock cycle while pts.ready is high. An accepted item passes
// these stages in order: one stage forms the 33-bit difference, one takes magnitudes,
// one folds into the first octant, two normalize the operands, ITERATIONS stages rotate,
// two unfold the angle, and the output register holds it. A skid stage behind the output
// register lets the pipeline run on while a finished result waits; pts.ready drops only
// after the consumer has stalled two results. Results leave in the order items came in;
// the block keeps no state between items.
module vector_angle_full_turn_top import vaft_pkg::*; #(
  parameter int unsigned ITERATIONS = ITERATIONS_DEF
) (
  input logic        clk,
  input logic        rst,
  vaft_in_if.sink    pts,
  vaft_out_if.source res
);

  // whole pipeline advances together unless the skid stage is full
  logic adv;

  // difference stage
  logic          dif_valid;
  logic [DW-1:0] dif_dx;
  logic [DW-1:0] dif_dy;

  // magnitude stage
  logic          mag_valid;
  logic [DW-1:0] mag_ax;
  logic [DW-1:0] mag_ay;
  logic          mag_eq;
  quad_t         mag_quad;
  logic          dx_pos;
  logic          dx_neg;
  logic          dy_pos;
  logic          dy_neg;
  quad_t         quad_next;

  // octant fold stage, operands pre-shifted so the magnitude msb sits at bit 32 + 26
  logic          ord_valid;
  logic [NW-1:0] ord_large;
  logic [NW-1:0] ord_small;
  side_t         ord_side;
  logic          swap_next;

  // coarse normalization stage (steps of 32, 16, 8)
  logic          crs_valid;
  logic [NW-1:0] crs_large;
  logic [NW-1:0] crs_small;
  side_t         crs_side;
  logic [NW-1:0] crs_large_next;
  logic [NW-1:0] crs_small_next;

  // fine normalization (steps of 4, 2, 1) feeding the rotation chain
  logic [NW-1:0] fin_large_next;
  logic [NW-1:0] fin_small_next;

  // rotation chain, entry 0 is the normalized operand register
  logic                 rv [0:ITERATIONS];
  logic signed [XW-1:0] rx [0:ITERATIONS];
  logic signed [XW-1:0] ry [0:ITERATIONS];
  logic signed [ZW-1:0] rz [0:ITERATIONS];
  side_t                rs [0:ITERATIONS];

  // clamp and unfold stage
  logic            oct_valid;
  logic [OW-1:0]   oct_a;
  side_t           oct_side;
  logic signed [ZW-1:0] z_fin;
  logic [FRAC-1:0] z_clamp;
  logic [OW-1:0]   oct_next;

  // full-turn stage
  logic          ful_valid;
  logic [FW-1:0] ful_angle;
  logic          ful_eq;
  logic [FW-1:0] ful_next;

  // rounding into the output register
  logic [63:0]   rnd_sum;
  logic [AW:0]   rnd_r;
  logic [AW-1:0] angle_next;
  logic          obuf_ready;

  assign adv       = obuf_ready;
  assign pts.ready = adv;

  // ---- exact 33-bit difference q - p
  always_ff @(posedge clk) begin
    if (rst) begin
      dif_valid <= 1'b0;
    end else if (adv) begin
      dif_valid <= pts.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dif_dx <= {pts.q_x[CW-1], pts.q_x} - {pts.p_x[CW-1], pts.p_x};
      dif_dy <= {pts.q_y[CW-1], pts.q_y} - {pts.p_y[CW-1], pts.p_y};
    end
  end

  // ---- magnitudes and quadrant choice
  assign dx_neg = dif_dx[DW-1];
  assign dy_neg = dif_dy[DW-1];
  assign dx_pos = !dx_neg && (dif_dx != '0);
  assign dy_pos = !dy_neg && (dif_dy != '0);

  always_comb begin
    if (!dy_neg && dx_pos) begin
      quad_next = QUAD_FIRST;
    end else if (dy_pos) begin
      quad_next = QUAD_SECOND;
    end else if (dx_neg) begin
      quad_next = QUAD_THIRD;
    end else begin
      // straight down lands here and gives 2*pi - pi/2
      quad_next = QUAD_FOURTH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mag_valid <= 1'b0;
    end else if (adv) begin
      mag_valid <= dif_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag_ax   <= dx_neg ? DW'(~dif_dx + 1'b1) : dif_dx;
      mag_ay   <= dy_neg ? DW'(~dif_dy + 1'b1) : dif_dy;
      mag_eq   <= (dif_dx == '0) && (dif_dy == '0);
      mag_quad <= quad_next;
    end
  end

  // ---- fold into the first octant: larger magnitude becomes x
  assign swap_next = mag_ay > mag_ax;

  always_ff @(posedge clk) begin
    if (rst) begin
      ord_valid <= 1'b0;
    end else if (adv) begin
      ord_valid <= mag_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ord_large     <= {(swap_next ? mag_ay : mag_ax), {(NW - DW){1'b0}}};
      ord_small     <= {(swap_next ? mag_ax : mag_ay), {(NW - DW){1'b0}}};
      ord_side.eq   <= mag_eq;
      ord_side.swap <= swap_next;
      ord_side.quad <= mag_quad;
    end
  end

  // ---- normalization, coarse steps: larger operand msb moves up into the top 8 bits
  always_comb begin
    crs_large_next = ord_large;
    crs_small_next = ord_small;
    if (crs_large_next[NW-1 -: 32] == '0) begin
      crs_large_next = crs_large_next << 32;
      crs_small_next = crs_small_next << 32;
    end
    if (crs_large_next[NW-1 -: 16] == '0) begin
      crs_large_next = crs_large_next << 16;
      crs_small_next = crs_small_next << 16;
    end
    if (crs_large_next[NW-1 -: 8] == '0) begin
      crs_large_next = crs_large_next << 8;
      crs_small_next = crs_small_next << 8;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crs_valid <= 1'b0;
    end else if (adv) begin
      crs_valid <= ord_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      crs_large <= crs_large_next;
      crs_small <= crs_small_next;
      crs_side  <= ord_side;
    end
  end

  // ---- normalization, fine steps
  always_comb begin
    fin_large_next = crs_large;
    fin_small_next = crs_small;
    if (fin_large_next[NW-1 -: 4] == '0) begin
      fin_large_next = fin_large_next << 4;
      fin_small_next = fin_small_next << 4;
    end
    if (fin_large_next[NW-1 -: 2] == '0) begin
      fin_large_next = fin_large_next << 2;
      fin_small_next = fin_small_next << 2;
    end
    if (!fin_large_next[NW-1]) begin
      fin_large_next = fin_large_next << 1;
      fin_small_next = fin_small_next << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rv[0] <= 1'b0;
    end else if (adv) begin
      rv[0] <= crs_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rx[0] <= signed'({{(XW - NW){1'b0}}, fin_large_next});
      ry[0] <= signed'({{(XW - NW){1'b0}}, fin_small_next});
      rz[0] <= '0;
      rs[0] <= crs_side;
    end
  end

  // ---- cordic micro-rotations, one per stage
  for (genvar i = 0; i < ITERATIONS; i++) begin : g_rot
    vaft_rot #(
      .STAGE(i)
    ) u_rot (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .in_valid (rv[i]),
      .x_in     (rx[i]),
      .y_in     (ry[i]),
      .z_in     (rz[i]),
      .side_in  (rs[i]),
      .out_valid(rv[i+1]),
      .x_out    (rx[i+1]),
      .y_out    (ry[i+1]),
      .z_out    (rz[i+1]),
      .side_out (rs[i+1])
    );
  end

  // ---- clamp the octant angle into [0, pi/4], unfold the swap
  assign z_fin = rz[ITERATIONS];

  always_comb begin
    if (z_fin[ZW-1]) begin
      z_clamp = '0;
    end else if (z_fin > signed'(ZW'(QUARTER_PI_F))) begin
      z_clamp = QUARTER_PI_F[FRAC-1:0];
    end else begin
      z_clamp = z_fin[FRAC-1:0];
    end
    if (rs[ITERATIONS].swap) begin
      oct_next = HALF_PI_F[OW-1:0] - OW'(z_clamp);
    end else begin
      oct_next = OW'(z_clamp);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oct_valid <= 1'b0;
    end else if (adv) begin
      oct_valid <= rv[ITERATIONS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      oct_a    <= oct_next;
      oct_side <= rs[ITERATIONS];
    end
  end

  // ---- place into the full turn
  always_comb begin
    case (oct_side.quad)
      QUAD_FIRST:  ful_next = FW'(oct_a);
      QUAD_SECOND: ful_next = PI_F[FW-1:0] - FW'(oct_a);
      QUAD_THIRD:  ful_next = PI_F[FW-1:0] + FW'(oct_a);
      QUAD_FOURTH: ful_next = TWO_PI_F[FW-1:0] - FW'(oct_a);
      default:     ful_next = FW'(oct_a);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ful_valid <= 1'b0;
    end else if (adv) begin
      ful_valid <= oct_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ful_angle <= ful_next;
      ful_eq    <= oct_side.eq;
    end
  end

  // ---- round to 29 fraction bits, saturate just below 2*pi
  assign rnd_sum = {{(64 - FW){1'b0}}, ful_angle} + 64'h0000_0000_4000_0000;
  assign rnd_r   = rnd_sum[31 +: AW + 1];

  always_comb begin
    if (ful_eq) begin
      angle_next = '0;
    end else if (rnd_r > {1'b0, ANGLE_MAX}) begin
      angle_next = ANGLE_MAX;
    end else begin
      angle_next = rnd_r[AW-1:0];
    end
  end

  vaft_obuf u_obuf (
    .clk     (clk),
    .rst     (rst),
    .in_valid(ful_valid),
    .angle_in(angle_next),
    .eq_in   (ful_eq),
    .in_ready(obuf_ready),
    .res     (res)
  );

endmodule

// ----- rtl/vaft_chk.sv -----
// port-level assertions for the vector angle block and their bind
module vaft_chk import vaft_pkg::*; (
  input logic          clk,
  input logic          rst,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input logic [AW-1:0] angle,
  input logic          points_equal
);

  // no result right after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(angle) && $stable(points_equal))
    else $error("stalled result changed");

  // equal points report a zero angle
  a_equal_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && points_equal |-> angle == '0)
    else $error("equal points with nonzero angle");

  // angle stays below 2*pi
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> angle <= ANGLE_MAX)
    else $error("angle above full turn");

  // input is held off only behind a result the consumer stalled
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> $past(out_valid && !out_ready))
    else $error("input stalled without output back-pressure");

endmodule

bind vector_angle_full_turn_top vaft_chk u_vaft_chk (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (pts.ready),
  .out_valid   (res.valid),
  .out_ready   (res.ready),
  .angle       (res.angle),
  .points_equal(res.points_equal)
);

// ----- dv/tb.sv -----
// self-checking testbench for the full-turn vector angle pipeline
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vaft_pkg::*;

  // rotation count of the unit under test, the predictor follows it
  localparam int unsigned ITER = ITERATIONS_DEF;
  // operands are normalized until this bit of the larger one is set
  localparam int unsigned NORM_TOP = NW - 1;
  // coordinate extremes
  localparam logic signed [31:0] CMIN = 32'sh8000_0000;
  localparam logic signed [31:0] CMAX = 32'sh7FFF_FFFF;
  // drain wait after the last phase, sized from ITER with margin on top
  localparam int unsigned DRAIN_CYCLES = ITER + 20;
  // watchdog limit, far above the slowest legal run
  localparam int unsigned CYCLE_LIMIT = 300000;

  // one expected result item
  typedef struct packed {
    logic [31:0] angle;
    logic        points_equal;
  } angle_result_t;

  logic clk = 1'b0;
  logic rst;

  vaft_in_if  pts_ch ();
  vaft_out_if res_ch ();

  vector_angle_full_turn_top #(
    .ITERATIONS(ITER)
  ) uut (
    .clk(clk),
    .rst(rst),
    .pts(pts_ch),
    .res(res_ch)
  );

  // expected angles in acceptance order
  angle_result_t pending_angles[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  // idling odds in percent, changed per phase
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // atan(2^-i) with 60 fraction bits: power series, every term truncated
  function automatic longint unsigned atan_inv_pow2(input int unsigned i);
    longint unsigned acc;
    longint unsigned term;
    int unsigned k;
    acc = 0;
    k = 0;
    if (i == 0) begin
      return QUARTER_PI_F;
    end
    for (int unsigned sh = i; sh < FRAC; sh += 2 * i) begin
      term = (64'd1 << FRAC) >> sh;
      term = term / longint'(2 * k + 1);
      // alternating signs of the series
      if (k % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
      k++;
    end
    return acc;
  endfunction

  // atan(lesser/big) in the first octant by cordic vectoring, big > 0
  function automatic longint unsigned cordic_octant(input longint unsigned big,
                                                    input longint unsigned lesser);
    int unsigned shift;
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    longint step;
    shift = 0;
    while ((big << shift) < (64'd1 << NORM_TOP)) begin
      shift++;
    end
    x = longint'(big << shift);
    y = longint'(lesser << shift);
    z = 0;
    for (int unsigned i = 0; i < ITER; i++) begin
      // floor shifts on the pre-rotation values
      xs = x >>> i;
      ys = y >>> i;
      step = longint'(atan_inv_pow2(i));
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + step;
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - step;
      end
    end
    // residual error may leave the octant slightly
    if (z < 0) begin
      z = 0;
    end
    if (longint'(QUARTER_PI_F) < z) begin
      z = longint'(QUARTER_PI_F);
    end
    return longint'(z);
  endfunction

  // full-turn direction of q - p, rounded to 29 fraction bits
  function automatic angle_result_t predict_direction(input logic signed [31:0] px, py,
                                                      qx, qy);
    angle_result_t r;
    longint dx;
    longint dy;
    longint unsigned ax;
    longint unsigned ay;
    longint unsigned oct;
    longint unsigned full;
    longint unsigned rounded;
    dx = longint'(qx) - longint'(px);
    dy = longint'(qy) - longint'(py);
    r.points_equal = 1'b0;
    // equal points carry the flag and a zero angle
    if (dx == 0 && dy == 0) begin
      r.angle = '0;
      r.points_equal = 1'b1;
      return r;
    end
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    // fold into the first octant, steep vectors measured from the y axis
    if (ay > ax) begin
      oct = HALF_PI_F - cordic_octant(ay, ax);
    end else begin
      oct = cordic_octant(ax, ay);
    end
    // unfold by quadrant, straight down lands in the fourth one
    if (dy >= 0 && dx > 0) begin
      full = oct;
    end else if (dy > 0) begin
      full = PI_F - oct;
    end else if (dx < 0) begin
      full = PI_F + oct;
    end else begin
      full = TWO_PI_F - oct;
    end
    rounded = (full + (64'd1 << 30)) >> 31;
    // a rounding up to a full turn is held just below it
    if (rounded > ANGLE_MAX) begin
      rounded = ANGLE_MAX;
    end
    r.angle = rounded[31:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // reset, receiver and watchdog
  // ---------------------------------------------------------------------------

  // result side: stall at the phase's odds
  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // compare every accepted result with the oldest expectation
  always @(posedge clk) begin
    angle_result_t want;
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (pending_angles.size() == 0) begin
        $error("unexpected result item: angle %0d, points_equal %0b",
               res_ch.angle, res_ch.points_equal);
        mismatch_count++;
      end else begin
        want = pending_angles.pop_front();
        if (res_ch.angle !== want.angle) begin
          $error("angle mismatch: expected %0d, actual %0d", want.angle, res_ch.angle);
          mismatch_count++;
        end
        if (res_ch.points_equal !== want.points_equal) begin
          $error("points_equal mismatch: expected %0b, actual %0b",
                 want.points_equal, res_ch.points_equal);
          mismatch_count++;
        end
      end
    end
  end

  // hard stop if the pipeline hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------------

  // offer one point pair, hold it until taken, then record its prediction
  task automatic send_pair(input logic signed [31:0] px, py, qx, qy);
    // idle cycles before the item at the phase's odds
    while ($urandom_range(99) < send_idle_pct) begin
      pts_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pts_ch.valid <= 1'b1;
    pts_ch.p_x <= px;
    pts_ch.p_y <= py;
    pts_ch.q_x <= qx;
    pts_ch.q_y <= qy;
    @(posedge clk);
    while (pts_ch.ready !== 1'b1) begin
      @(posedge clk);
    end
    pending_angles.push_back(predict_direction(px, py, qx, qy));
  endtask

  // stop offering and wait until every expected result is back
  task automatic wait_drained();
    pts_ch.valid <= 1'b0;
    while (pending_angles.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // a coordinate from the corner values or anywhere
  function automatic logic signed [31:0] pick_corner();
    case ($urandom_range(5))
      0: return CMIN;
      1: return CMAX;
      2: return 32'sd0;
      3: return -32'sd1;
      4: return 32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // coincident points, including at the coordinate extremes
  task automatic test_equal_points();
    send_pair(0, 0, 0, 0);
    send_pair(CMIN, CMAX, CMIN, CMAX);
    send_pair(-5, 7, -5, 7);
    wait_drained();
  endtask

  // vectors along the axes, unit length and widest span
  task automatic test_axes();
    send_pair(0, 0, 1, 0);          // right
    send_pair(0, 0, -1, 0);         // left
    send_pair(0, 0, 0, 1);          // straight up
    send_pair(0, 0, 0, -1);         // straight down
    send_pair(CMIN, 0, CMAX, 0);    // widest right
    send_pair(CMAX, 5, CMIN, 5);    // widest left
    send_pair(3, CMIN, 3, CMAX);    // widest up
    send_pair(3, CMAX, 3, CMIN);    // widest down
    wait_drained();
  endtask

  // the four diagonals and both sides of the octant fold
  task automatic test_diagonals();
    send_pair(0, 0, 1, 1);
    send_pair(0, 0, -1, 1);
    send_pair(0, 0, -1, -1);
    send_pair(0, 0, 1, -1);
    send_pair(0, 0, CMAX, CMAX - 1);
    send_pair(0, 0, CMAX - 1, CMAX);
    wait_drained();
  endtask

  // largest differences, and angles just around zero and a full turn
  task automatic test_extremes();
    send_pair(CMIN, 0, CMAX, -1);   // just below a full turn, saturates
    send_pair(CMIN, 0, CMAX, 1);    // just above zero
    send_pair(CMIN, CMIN, CMAX, CMAX);
    send_pair(CMAX, CMAX, CMIN, CMIN);
    send_pair(CMAX, CMIN, CMIN, CMAX);
    send_pair(CMIN, CMAX, CMAX, CMIN);
    wait_drained();
  endtask

  // random pairs under one idling pattern, mixed toward the special regions
  task automatic test_random_stream(input int count, input int send_pct, input int recv_pct);
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    int jitter;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    for (int n = 0; n < count; n++) begin
      // keep p away from the rails so that q = p + d does not wrap; the fully random case redraws p
      px = $signed($urandom) >>> 2;
      py = $signed($urandom) >>> 2;
      case ($urandom_range(9))
        4: begin
          // coincident points anywhere
          px = $urandom;
          py = $urandom;
          dx = 0;
          dy = 0;
        end
        5: begin
          // tiny vectors hit axes, diagonals and equal points often
          dx = int'($urandom_range(16)) - 8;
          dy = int'($urandom_range(16)) - 8;
        end
        6: begin
          // close to the x axis
          dx = $signed($urandom) >>> 1;
          dy = int'($urandom_range(6)) - 3;
        end
        7: begin
          // close to the y axis
          dx = int'($urandom_range(6)) - 3;
          dy = $signed($urandom) >>> 1;
        end
        8: begin
          // close to a diagonal, either side of the fold
          dx = $urandom_range(32'h3FFF_FFFF);
          jitter = int'($urandom_range(2)) - 1;
          dy = dx + jitter;
          if ($urandom_range(1)) dx = -dx;
          if ($urandom_range(1)) dy = -dy;
        end
        9: begin
          // corner coordinates, differences may span the full 33 bits
          px = pick_corner();
          py = pick_corner();
          send_pair(px, py, pick_corner(), pick_corner());
          continue;
        end
        default: begin
          // fully random coordinates
          px = $urandom;
          py = $urandom;
          dx = $urandom;
          dy = $urandom;
        end
      endcase
      send_pair(px, py, px + dx, py + dy);
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst <= 1'b1;
    pts_ch.valid <= 1'b0;
    pts_ch.p_x <= '0;
    pts_ch.p_y <= '0;
    pts_ch.q_x <= '0;
    pts_ch.q_y <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed items run back to back
    test_equal_points();
    test_axes();
    test_diagonals();
    test_extremes();

    // random items, one phase per idling pattern
    test_random_stream(163, 0, 0);
    test_random_stream(163, 71, 0);
    test_random_stream(163, 0, 71);
    test_random_stream(163, 33, 33);

    // let any stray result surface before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
